>>> hw/rtl/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types and codes for the byte pipe: operation and status codes,
// transaction payloads and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package pbf_pkg;

  typedef enum logic [2:0] {
    OpWrite    = 3'd0,
    OpRead     = 3'd1,
    OpDupRead  = 3'd2,
    OpDupWrite = 3'd3,
    OpClsRead  = 3'd4,
    OpClsWrite = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEof      = 3'd1,
    StBroken   = 3'd2,
    StBlock    = 3'd3,
    StClosed   = 3'd4,
    StOverflow = 3'd5
  } status_e;

  typedef enum logic {
    StateIdle = 1'b0,
    StateExec = 1'b1
  } state_e;

  localparam int unsigned FillW = 10;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] write_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       read_byte;
    logic [FillW-1:0] fill_level;
    logic             pipe_dead;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // latch item, read store at read position
    logic exec;  // apply operation, register result
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/pbf_ctrl.sv
// ----------------------------------------------------------------------------
// pbf_ctrl
// Two-state sequencer: takes a transaction, runs the execute state, then
// strobes the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output pbf_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  pbf_pkg::state_e state_q, state_d;
  logic            done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbf_pkg::StateIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    busy_o     = 1'b0;
    unique case (state_q)
      pbf_pkg::StateIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = pbf_pkg::StateExec;
        end
      end
      pbf_pkg::StateExec: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = pbf_pkg::StateIdle;
      end
      default: state_d = pbf_pkg::StateIdle;
    endcase
  end

  assign done_o = done_q;

  a_load_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == pbf_pkg::StateExec))
    else $error("load not followed by execute");

  a_exec_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (done_q && state_q == pbf_pkg::StateIdle))
    else $error("execute not followed by result strobe");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.exec))
    else $error("load and execute together");

endmodule

`default_nettype wire

>>> hw/rtl/pbf_datapath.sv
// ----------------------------------------------------------------------------
// pbf_datapath
// Ring store, positions, fill count and end reference counts; applies one
// operation per execute command and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_datapath #(
  parameter int unsigned PIPE_DEPTH = 512,
  parameter int unsigned MAX_REFS   = 15
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pbf_pkg::cmd_t cmd_i,
  input  wire pbf_pkg::in_t  in_i,
  output pbf_pkg::out_t      out_o
);

  localparam int unsigned PtrW = $clog2(PIPE_DEPTH);
  localparam int unsigned CntW = $clog2(PIPE_DEPTH + 1);
  localparam int unsigned RefW = $clog2(MAX_REFS + 1);
  localparam logic [PtrW-1:0] LastPos = PtrW'(PIPE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(PIPE_DEPTH);
  localparam logic [RefW-1:0] RefMax  = RefW'(MAX_REFS);
  localparam logic [RefW-1:0] RefOne  = RefW'(1);

  logic [7:0]      mem_q [PIPE_DEPTH];
  logic [7:0]      rdata_q;
  pbf_pkg::in_t    item_q;
  pbf_pkg::out_t   out_q, out_d;

  logic [PtrW-1:0] wpos_q, wpos_d, rpos_q, rpos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RefW-1:0] rrefs_q, rrefs_d, wrefs_q, wrefs_d;
  logic            mem_we;
  pbf_pkg::status_e st;
  logic [7:0]      rbyte;
  logic [CntW+pbf_pkg::FillW-1:0] cnt_ext;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wpos_q] <= item_q.write_byte;
    end
    if (cmd_i.load) begin
      rdata_q <= mem_q[rpos_q];
      item_q  <= in_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q  <= '0;
      rpos_q  <= '0;
      cnt_q   <= '0;
      rrefs_q <= RefOne;
      wrefs_q <= RefOne;
    end else begin
      wpos_q  <= wpos_d;
      rpos_q  <= rpos_d;
      cnt_q   <= cnt_d;
      rrefs_q <= rrefs_d;
      wrefs_q <= wrefs_d;
    end
  end

  always_comb begin
    wpos_d  = wpos_q;
    rpos_d  = rpos_q;
    cnt_d   = cnt_q;
    rrefs_d = rrefs_q;
    wrefs_d = wrefs_q;
    mem_we  = 1'b0;
    st      = pbf_pkg::StOk;
    rbyte   = 8'd0;
    if (cmd_i.exec) begin
      unique case (item_q.op)
        pbf_pkg::OpWrite: begin
          priority if (wrefs_q == '0) begin
            st = pbf_pkg::StClosed;
          end else if (cnt_q >= FullCnt) begin
            st = (rrefs_q == '0) ? pbf_pkg::StBroken : pbf_pkg::StBlock;
          end else begin
            mem_we = 1'b1;
            wpos_d = (wpos_q == LastPos) ? '0 : wpos_q + PtrW'(1);
            cnt_d  = cnt_q + CntW'(1);
          end
        end
        pbf_pkg::OpRead: begin
          priority if (rrefs_q == '0) begin
            st = pbf_pkg::StClosed;
          end else if (cnt_q == '0) begin
            st = (wrefs_q == '0) ? pbf_pkg::StEof : pbf_pkg::StBlock;
          end else begin
            rbyte  = rdata_q;
            rpos_d = (rpos_q == LastPos) ? '0 : rpos_q + PtrW'(1);
            cnt_d  = cnt_q - CntW'(1);
          end
        end
        pbf_pkg::OpDupRead: begin
          priority if (rrefs_q == '0) st = pbf_pkg::StClosed;
          else if (rrefs_q >= RefMax) st = pbf_pkg::StOverflow;
          else rrefs_d = rrefs_q + RefW'(1);
        end
        pbf_pkg::OpDupWrite: begin
          priority if (wrefs_q == '0) st = pbf_pkg::StClosed;
          else if (wrefs_q >= RefMax) st = pbf_pkg::StOverflow;
          else wrefs_d = wrefs_q + RefW'(1);
        end
        pbf_pkg::OpClsRead: begin
          if (rrefs_q == '0) st = pbf_pkg::StClosed;
          else rrefs_d = rrefs_q - RefW'(1);
        end
        pbf_pkg::OpClsWrite: begin
          if (wrefs_q == '0) st = pbf_pkg::StClosed;
          else wrefs_d = wrefs_q - RefW'(1);
        end
        default: ;  // unused codes: no change
      endcase
    end
    cnt_ext          = {{pbf_pkg::FillW{1'b0}}, cnt_d};
    out_d.status     = st;
    out_d.read_byte  = rbyte;
    out_d.fill_level = cnt_ext[pbf_pkg::FillW-1:0];
    out_d.pipe_dead  = (rrefs_d == '0) && (wrefs_d == '0);
  end

  assign out_o = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("fill count above depth");

  a_refs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rrefs_q <= RefMax) && (wrefs_q <= RefMax))
    else $error("reference count above maximum");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(cnt_q) && $stable(rrefs_q) && $stable(wrefs_q))
    else $error("state changed outside execute");

endmodule

`default_nettype wire

>>> hw/rtl/pipe_byte_fifo_with_end_refcounts_core.sv
// ----------------------------------------------------------------------------
// pipe_byte_fifo_with_end_refcounts_core
// Byte pipe: ring FIFO with read-end and write-end reference counts.
// ----------------------------------------------------------------------------
// Result: a transaction's result is strobed on done_o in the cycle after
//   its execute cycle.
// Issue: store read, then execute; start_i is ignored during execute.
// The receiver cannot stall; each result is strobed for exactly one cycle.
// Reset: positions and fill count clear, both reference counts go to one;
//   the byte store is not cleared.
`default_nettype none

module pipe_byte_fifo_with_end_refcounts_core #(
  parameter int unsigned PIPE_DEPTH = 512,
  parameter int unsigned MAX_REFS   = 15
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire pbf_pkg::in_t in_i,
  output logic              busy_o,
  output logic              done_o,
  output pbf_pkg::out_t     out_o
);

  pbf_pkg::cmd_t cmd;

  pbf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  pbf_datapath #(
    .PIPE_DEPTH (PIPE_DEPTH),
    .MAX_REFS   (MAX_REFS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
